/* hw/rtl/sav_pkg.sv */
// Shared types, constants and helper functions of the squeezed arc vertex generator.
package sav_pkg;

  localparam int MAX_POINTS_DEF    = 1024;
  localparam int CORDIC_STAGES_DEF = 20;

  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] IDX_CENTER_X = 3'd0;
  localparam logic [IDX_W-1:0] IDX_CENTER_Y = 3'd1;
  localparam logic [IDX_W-1:0] IDX_RADIUS   = 3'd2;
  localparam logic [IDX_W-1:0] IDX_POINTS   = 3'd3;
  localparam logic [IDX_W-1:0] IDX_WAVE     = 3'd4;
  localparam logic [IDX_W-1:0] IDX_SLIT     = 3'd5;
  localparam logic [IDX_W-1:0] IDX_OFFSET   = 3'd6;

  localparam int NUM_W = 40;   // phase dividend width
  localparam int CNT_W = 11;   // point count width
  localparam int PH_W  = 32;   // phase kept mod four quarter turns, Q30
  localparam int CW    = 33;   // CORDIC datapath width

  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

  typedef struct packed {
    logic        busy;
    logic [30:0] f;
    logic [30:0] rf;
  } sav_scale_t;

  function automatic logic [31:0] sav_atan(input int k);
    logic [31:0] a;
    case (k)
      0: a = 32'd843314856;   1: a = 32'd497837829;   2: a = 32'd263043836;
      3: a = 32'd133525158;   4: a = 32'd67021686;    5: a = 32'd33543515;
      6: a = 32'd16775850;    7: a = 32'd8388437;     8: a = 32'd4194282;
      9: a = 32'd2097149;     10: a = 32'd1048575;    11: a = 32'd524287;
      12: a = 32'd262143;     13: a = 32'd131071;     14: a = 32'd65535;
      15: a = 32'd32767;      16: a = 32'd16383;      17: a = 32'd8191;
      18: a = 32'd4095;       19: a = 32'd2047;       20: a = 32'd1023;
      21: a = 32'd511;        22: a = 32'd255;        23: a = 32'd127;
      24: a = 32'd63;         25: a = 32'd31;         26: a = 32'd15;
      27: a = 32'd7;          28: a = 32'd3;          29: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  function automatic logic [31:0] sav_sat(input logic signed [36:0] v);
    logic [31:0] r;
    if (v > 37'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -37'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* hw/rtl/sav_squeeze.sv */
// Squeeze factor unit: serial divider for f and a multiply for the scaled radius, rerun on register writes.
module sav_squeeze (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [30:0]      wave_length,
  input  logic [30:0]      slit_width,
  input  logic [30:0]      radius,
  output sav_pkg::sav_scale_t scale
);

  typedef enum logic [3:0] {
    SQ_IDLE  = 4'b0001,
    SQ_LOAD  = 4'b0010,
    SQ_DIV   = 4'b0100,
    SQ_SCALE = 4'b1000
  } sq_state_t;

  localparam logic [4:0] LAST_STEP = 5'd29;

  sq_state_t   state;
  logic [30:0] rem;
  logic [28:0] quo;
  logic [4:0]  cnt;
  logic [30:0] f;
  logic [30:0] rf;
  logic [31:0] rem_sh;
  logic        ge;
  logic [61:0] prod;

  assign rem_sh = {rem, 1'b0};
  assign ge     = rem_sh >= {1'b0, slit_width};
  assign prod   = 62'(radius) * 62'(f);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
      f     <= sav_pkg::ONE_Q30;
      rf    <= 31'd65536;
      cnt   <= '0;
    end else if (start) begin
      state <= SQ_LOAD;
    end else begin
      case (state)
        SQ_LOAD: begin
          cnt <= '0;
          quo <= '0;
          rem <= wave_length;
          if (slit_width != '0 && wave_length < slit_width) begin
            state <= SQ_DIV;
          end else begin
            f     <= sav_pkg::ONE_Q30;
            state <= SQ_SCALE;
          end
        end
        SQ_DIV: begin
          rem <= ge ? 31'(rem_sh - {1'b0, slit_width}) : rem_sh[30:0];
          quo <= {quo[27:0], ge};
          cnt <= cnt + 5'd1;
          if (cnt == LAST_STEP) begin
            f     <= {1'b0, quo[28:0], ge};
            state <= SQ_SCALE;
          end
        end
        SQ_SCALE: begin
          rf    <= prod[60:30];
          state <= SQ_IDLE;
        end
        default: state <= SQ_IDLE;
      endcase
    end
  end

  assign scale.busy = state != SQ_IDLE;
  assign scale.f    = f;
  assign scale.rf   = rf;

endmodule

/* hw/rtl/sav_phase_div.sv */
// Pipelined two-lane restoring divider: phase numerators over the point count, one bit a stage.
module sav_phase_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0][sav_pkg::NUM_W-1:0]       num,
  input  logic [sav_pkg::CNT_W-1:0]            divisor,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0][sav_pkg::PH_W-1:0]        quot
);

  localparam int D  = sav_pkg::NUM_W;
  localparam int NW = sav_pkg::CNT_W;

  logic [D-1:0] v;
  logic [D:0]   rdy;
  logic [NW-1:0] rem  [0:D-1][0:1];
  logic [D-1:0]  work [0:D-1][0:1];

  assign rdy[D] = out_ready;

  for (genvar k = 0; k < D; k++) begin : g_st
    assign rdy[k] = !v[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k-1];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_ln
      logic [NW-1:0] src_rem;
      logic [D-1:0]  src_work;
      logic [NW:0]   t;
      logic          ge;
      if (k == 0) begin : g_first
        assign src_rem  = '0;
        assign src_work = num[l];
      end else begin : g_next
        assign src_rem  = rem[k-1][l];
        assign src_work = work[k-1][l];
      end
      assign t  = {src_rem, src_work[D-1]};
      assign ge = t >= {1'b0, divisor};
      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          rem[k][l]  <= ge ? NW'(t - {1'b0, divisor}) : t[NW-1:0];
          work[k][l] <= {src_work[D-2:0], ge};
        end
      end
      if (k == D-1) begin : g_out
        assign quot[l] = work[D-1][l][sav_pkg::PH_W-1:0];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[D-1];

endmodule

/* hw/rtl/sav_cordic.sv */
// Pipelined two-lane rotation CORDIC: phase in quarter turns to cosine and sine, Q30.
module sav_cordic #(
  parameter int STAGES = sav_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0][sav_pkg::PH_W-1:0]         phase,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0][sav_pkg::CW-1:0]           cos_q,
  output logic [1:0][sav_pkg::CW-1:0]           sin_q
);

  localparam int W = sav_pkg::CW;
  localparam int D = STAGES + 2;

  logic [D-1:0] v;
  logic [D:0]   rdy;
  logic signed [W-1:0] x [0:STAGES][0:1];
  logic signed [W-1:0] y [0:STAGES][0:1];
  logic signed [W-1:0] z [0:STAGES][0:1];
  logic [1:0]          quad [0:STAGES][0:1];

  assign rdy[D] = out_ready;

  for (genvar k = 0; k < D; k++) begin : g_v
    assign rdy[k] = !v[k] || rdy[k+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_ln
    logic [60:0] zp;
    assign zp = 61'(phase[l][29:0]) * 61'(sav_pkg::HALF_PI_Q30);

    // phase fraction to radians
    always_ff @(posedge clk) begin
      if (rdy[0]) begin
        x[0][l]    <= sav_pkg::CORDIC_GAIN;
        y[0][l]    <= '0;
        z[0][l]    <= $signed({2'b00, zp[60:30]});
        quad[0][l] <= phase[l][31:30];
      end
    end

    for (genvar k = 1; k <= STAGES; k++) begin : g_it
      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          quad[k][l] <= quad[k-1][l];
          if (!z[k-1][l][W-1]) begin
            x[k][l] <= x[k-1][l] - (y[k-1][l] >>> (k-1));
            y[k][l] <= y[k-1][l] + (x[k-1][l] >>> (k-1));
            z[k][l] <= z[k-1][l] - $signed(W'(sav_pkg::sav_atan(k-1)));
          end else begin
            x[k][l] <= x[k-1][l] + (y[k-1][l] >>> (k-1));
            y[k][l] <= y[k-1][l] - (x[k-1][l] >>> (k-1));
            z[k][l] <= z[k-1][l] + $signed(W'(sav_pkg::sav_atan(k-1)));
          end
        end
      end
    end

    // quadrant rotation
    always_ff @(posedge clk) begin
      if (rdy[D-1]) begin
        case (quad[STAGES][l])
          2'd0: begin cos_q[l] <= x[STAGES][l];  sin_q[l] <= y[STAGES][l];  end
          2'd1: begin cos_q[l] <= -y[STAGES][l]; sin_q[l] <= x[STAGES][l];  end
          2'd2: begin cos_q[l] <= -x[STAGES][l]; sin_q[l] <= -y[STAGES][l]; end
          default: begin cos_q[l] <= y[STAGES][l]; sin_q[l] <= -x[STAGES][l]; end
        endcase
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[D-1];

endmodule

/* hw/rtl/squeezed_arc_vertex_generator.sv */
// Top level: configuration registers, phase setup, pipeline assembly and output scaling.
//
// One point index is taken per clock unless the pipeline or the squeeze divider holds it; each
// vertex passes one setup stage, a 40-stage bit-per-stage phase divider, a CORDIC_STAGES + 2
// stage CORDIC, a multiply stage and a round/saturate output register. Stalls on the output back
// up the pipeline stage by stage, filling bubbles first. A write to radius, wave_length or
// slit_width reruns the serial squeeze factor divider, which holds in_ready low while it runs
// and skips the division when no squeeze applies.
module squeezed_arc_vertex_generator #(
  parameter int MAX_POINTS    = sav_pkg::MAX_POINTS_DEF,
  parameter int CORDIC_STAGES = sav_pkg::CORDIC_STAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [sav_pkg::IDX_W-1:0]   cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [9:0]                  point_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          vertex_x,
  output logic signed [31:0]          upper_y,
  output logic signed [31:0]          mirror_y
);

  localparam int NW = sav_pkg::NUM_W;

  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic [30:0]        radius;
  logic [10:0]        point_count;
  logic [30:0]        wave_length;
  logic [30:0]        slit_width;
  logic signed [31:0] vertical_offset;

  logic [10:0] pc_next;
  always_comb begin
    pc_next = cfg_data[10:0];
    if ({6'b0, pc_next} > 17'(MAX_POINTS)) pc_next = 11'(MAX_POINTS);
    if (pc_next == '0) pc_next = 11'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x        <= '0;
      center_y        <= '0;
      radius          <= 31'd65536;
      point_count     <= 11'd64;
      wave_length     <= 31'd65536;
      slit_width      <= 31'd65536;
      vertical_offset <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        sav_pkg::IDX_CENTER_X: center_x        <= cfg_data;
        sav_pkg::IDX_CENTER_Y: center_y        <= cfg_data;
        sav_pkg::IDX_RADIUS:   radius          <= cfg_data[30:0];
        sav_pkg::IDX_POINTS:   point_count     <= pc_next;
        sav_pkg::IDX_WAVE:     wave_length     <= cfg_data[30:0];
        sav_pkg::IDX_SLIT:     slit_width      <= cfg_data[30:0];
        sav_pkg::IDX_OFFSET:   vertical_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  sav_pkg::sav_scale_t sq;
  logic sq_start;
  assign sq_start = cfg_write && (cfg_index == sav_pkg::IDX_RADIUS ||
                    cfg_index == sav_pkg::IDX_WAVE || cfg_index == sav_pkg::IDX_SLIT);

  sav_squeeze u_squeeze (
    .clk         (clk),
    .rst         (rst),
    .start       (sq_start),
    .wave_length (wave_length),
    .slit_width  (slit_width),
    .radius      (radius),
    .scale       (sq)
  );

  // setup stage: phase numerators, lane 0 theta, lane 1 f*theta
  logic                 mv;
  logic                 ready_m;
  logic [1:0][NW-1:0]   num;
  logic                 dv_in_ready;
  logic [NW-1:0]        iq;

  assign iq       = NW'(point_index) * NW'(sq.f);
  assign ready_m  = !mv || dv_in_ready;
  assign in_ready = ready_m && !sq.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (ready_m) begin
      mv <= in_valid && !sq.busy;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_m) begin
      num[0] <= {point_index, 30'b0};
      num[1] <= iq;
    end
  end

  logic                             dv_out_valid;
  logic                             cd_in_ready;
  logic [1:0][sav_pkg::PH_W-1:0]    phase;

  sav_phase_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mv),
    .in_ready  (dv_in_ready),
    .num       (num),
    .divisor   (point_count),
    .out_valid (dv_out_valid),
    .out_ready (cd_in_ready),
    .quot      (phase)
  );

  logic                           cd_out_valid;
  logic                           ready_p;
  logic [1:0][sav_pkg::CW-1:0]    cos_q;
  logic [1:0][sav_pkg::CW-1:0]    sin_q;

  sav_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_out_valid),
    .in_ready  (cd_in_ready),
    .phase     (phase),
    .out_valid (cd_out_valid),
    .out_ready (ready_p),
    .cos_q     (cos_q),
    .sin_q     (sin_q)
  );

  // multiply stage
  logic               pv;
  logic               ready_o;
  logic signed [64:0] px;
  logic signed [64:0] py;

  assign ready_p = !pv || ready_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (ready_p) begin
      pv <= cd_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_p) begin
      px <= 65'($signed({1'b0, sq.rf})) * 65'($signed(cos_q[1]));
      py <= 65'($signed({1'b0, radius})) * 65'($signed(sin_q[0]));
    end
  end

  // round, offset and saturate
  logic signed [64:0] pxr;
  logic signed [64:0] pyr;
  logic signed [36:0] dx;
  logic signed [36:0] dy;
  logic signed [36:0] yc;
  logic signed [36:0] sx;
  logic signed [36:0] su;
  logic signed [36:0] sm;
  logic signed [36:0] vo;

  assign pxr = px + 65'sd536870912;
  assign pyr = py + 65'sd536870912;
  assign dx  = {{2{pxr[64]}}, pxr[64:30]};
  assign dy  = {{2{pyr[64]}}, pyr[64:30]};
  assign vo  = {{5{vertical_offset[31]}}, vertical_offset};
  assign yc  = {{5{center_y[31]}}, center_y} - dy;
  assign sx  = {{5{center_x[31]}}, center_x} + dx;
  assign su  = yc - vo;
  assign sm  = vo - yc;

  assign ready_o = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_o) begin
      out_valid <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o) begin
      vertex_x <= sav_pkg::sav_sat(sx);
      upper_y  <= sav_pkg::sav_sat(su);
      mirror_y <= sav_pkg::sav_sat(sm);
    end
  end

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst) sq.busy |-> !in_ready)
    else $error("input taken while squeeze factor is being recomputed");
  a_write_starts: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg_index == sav_pkg::IDX_SLIT) |=> sq.busy)
    else $error("slit width write did not restart the squeeze divider");
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> mv)
    else $error("accepted index missing from setup stage");
  a_f_range: assert property (@(posedge clk) disable iff (rst)
    !sq.busy |-> sq.f <= sav_pkg::ONE_Q30)
    else $error("squeeze factor above one");

endmodule

/* test/squeezed_arc_vertex_generator_tb.sv */
// Self-checking testbench for the squeezed arc vertex generator, with a predictor and randomized handshakes.
module squeezed_arc_vertex_generator_tb;

  localparam int STAGES = 20;
  localparam logic [sav_pkg::IDX_W-1:0] IDX_UNUSED = 3'd7;
  localparam longint ARCTAN_Q30 [0:19] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850, 8388437,
    4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047};

  typedef struct {
    logic signed [31:0] vx;
    logic signed [31:0] uy;
    logic signed [31:0] my;
  } vertex_t;

  logic clk, rst;
  logic cfg_write;
  logic [sav_pkg::IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [9:0] point_index;
  logic signed [31:0] vertex_x, upper_y, mirror_y;

  squeezed_arc_vertex_generator DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .point_index(point_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .vertex_x(vertex_x), .upper_y(upper_y), .mirror_y(mirror_y)
  );

  // arc settings as the block should hold them
  longint arc_cx, arc_cy, arc_radius, arc_points, arc_wave, arc_slit, arc_offset;

  logic [9:0] index_queue[$];
  vertex_t vertex_queue[$];
  int errors = 0;
  bit no_idle;
  int send_gap, recv_stall;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // phase in quarter turns (Q30) to sin/cos in Q30
  function automatic void quarter_sincos(input logic [63:0] ph, output longint s,
                                         output longint c);
    logic [63:0] frac;
    longint z, x, y, xs, ys;
    frac = {34'd0, ph[29:0]};
    z = longint'((frac * 64'd1686629713) >> 30);
    x = 652032874;
    y = 0;
    for (int k = 0; k < STAGES; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ARCTAN_Q30[k];
      end else begin
        x = x + ys; y = y - xs; z = z + ARCTAN_Q30[k];
      end
    end
    case (ph[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic vertex_t arc_vertex(input logic [9:0] idx);
    vertex_t r;
    logic [63:0] n, f, p, q, rf, i;
    longint st, ct, sf, cf, dx, dy, y;
    i = {54'd0, idx};
    n = (arc_points == 0) ? 64'd1 : arc_points;
    f = 64'd1 << 30;
    if (arc_slit != 0 && arc_wave < arc_slit) f = (arc_wave << 30) / arc_slit;
    p = (i << 30) / n;
    q = (i * f) / n;
    quarter_sincos(p, st, ct);
    quarter_sincos(q, sf, cf);
    rf = (arc_radius * f) >> 30;
    dx = (longint'(rf) * cf + (64'sd1 << 29)) >>> 30;
    dy = (arc_radius * st + (64'sd1 << 29)) >>> 30;
    y = arc_cy - dy;
    r.vx = 32'(clamp32(arc_cx + dx));
    r.uy = 32'(clamp32(y - arc_offset));
    r.my = 32'(clamp32(arc_offset - y));
    return r;
  endfunction

  task automatic reg_write(input logic [sav_pkg::IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      sav_pkg::IDX_CENTER_X: arc_cx = longint'(signed'(val));
      sav_pkg::IDX_CENTER_Y: arc_cy = longint'(signed'(val));
      sav_pkg::IDX_RADIUS:   arc_radius = val[30:0];
      sav_pkg::IDX_POINTS:   arc_points = (val[10:0] > 1024) ? 1024 : val[10:0];
      sav_pkg::IDX_WAVE:     arc_wave = val[30:0];
      sav_pkg::IDX_SLIT:     arc_slit = val[30:0];
      sav_pkg::IDX_OFFSET:   arc_offset = longint'(signed'(val));
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // sampled at the falling edge, after the clocked blocks have settled
  task automatic drain();
    while (index_queue.size() != 0 || in_valid || vertex_queue.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return $urandom;
      default: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'd0;
      2: return $urandom;
      default: return $urandom_range(1, 32'h0040_0000);
    endcase
  endfunction

  // sender: one pending index at a time, random gap after each transfer
  always @(posedge clk) begin : sender
    logic holding;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      holding = in_valid;
      if (in_valid && in_ready) begin
        vertex_queue.push_back(arc_vertex(point_index));
        holding = 1'b0;
      end
      if (!holding) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (index_queue.size() != 0) begin
          point_index <= index_queue.pop_front();
          in_valid <= 1'b1;
          send_gap <= no_idle ? 0 : $urandom_range(0, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each transfer against the oldest predicted vertex
  always @(posedge clk) begin : receiver
    vertex_t want;
    int s;
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (vertex_queue.size() == 0) begin
          $display("%0t: unexpected vertex x=%0d uy=%0d my=%0d", $time,
                   vertex_x, upper_y, mirror_y);
          errors++;
        end else begin
          want = vertex_queue.pop_front();
          if (vertex_x !== want.vx) begin
            $display("%0t: vertex_x exp %0d got %0d", $time, want.vx, vertex_x);
            errors++;
          end
          if (upper_y !== want.uy) begin
            $display("%0t: upper_y exp %0d got %0d", $time, want.uy, upper_y);
            errors++;
          end
          if (mirror_y !== want.my) begin
            $display("%0t: mirror_y exp %0d got %0d", $time, want.my, mirror_y);
            errors++;
          end
        end
        s = no_idle ? 0 : $urandom_range(0, 8);
        recv_stall <= s;
        out_ready <= (s == 0);
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ready <= (recv_stall == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    no_idle = 0;
    arc_cx = 0; arc_cy = 0; arc_radius = 65536; arc_points = 64;
    arc_wave = 65536; arc_slit = 65536; arc_offset = 0;
    rst = 1'b1;
    cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, boundary indices
    index_queue = '{10'd0, 10'd1, 10'd32, 10'd63, 10'd64, 10'd65, 10'd128, 10'd255,
                    10'd512, 10'd1023, 10'h2aa, 10'h155};
    drain();

    // directed: extreme settings, squeeze, out-of-range index, count saturation
    reg_write(sav_pkg::IDX_CENTER_X, 32'h7fff_ffff);
    reg_write(sav_pkg::IDX_CENTER_Y, 32'h8000_0000);
    reg_write(sav_pkg::IDX_RADIUS, 32'hffff_ffff);
    reg_write(sav_pkg::IDX_POINTS, 32'd0);
    reg_write(sav_pkg::IDX_OFFSET, 32'h7fff_ffff);
    reg_write(IDX_UNUSED, 32'h1234_5678);
    index_queue = '{10'd0, 10'd1, 10'd1023, 10'd2};
    drain();
    reg_write(sav_pkg::IDX_POINTS, 32'hffff_ffff);
    reg_write(sav_pkg::IDX_WAVE, 32'd1);
    reg_write(sav_pkg::IDX_SLIT, 32'h7fff_ffff);
    reg_write(sav_pkg::IDX_OFFSET, 32'h8000_0000);
    index_queue = '{10'd0, 10'd512, 10'd1023, 10'd1000};
    drain();
    reg_write(sav_pkg::IDX_SLIT, 32'd0);
    reg_write(sav_pkg::IDX_POINTS, 32'd1);
    reg_write(sav_pkg::IDX_CENTER_X, 32'h8000_0000);
    reg_write(sav_pkg::IDX_RADIUS, 32'd0);
    index_queue = '{10'd0, 10'd1, 10'd3, 10'd1023};
    drain();

    // random phases, each with fresh settings
    for (int ph = 0; ph < 14; ph++) begin
      reg_write(sav_pkg::IDX_CENTER_X, pick_coord());
      reg_write(sav_pkg::IDX_CENTER_Y, pick_coord());
      reg_write(sav_pkg::IDX_OFFSET, pick_coord());
      reg_write(sav_pkg::IDX_RADIUS, pick_length());
      reg_write(sav_pkg::IDX_WAVE, pick_length());
      reg_write(sav_pkg::IDX_SLIT, pick_length());
      case ($urandom_range(0, 3))
        0: reg_write(sav_pkg::IDX_POINTS, $urandom_range(0, 2));
        1: reg_write(sav_pkg::IDX_POINTS, $urandom_range(1020, 2047));
        default: reg_write(sav_pkg::IDX_POINTS, $urandom_range(1, 1024));
      endcase
      no_idle = (ph % 4 == 3);
      for (int k = 0; k < 104; k++) begin
        if ($urandom_range(0, 3) == 0 && arc_points > 0)
          index_queue.push_back(10'($urandom_range(0, 32'(arc_points - 1))));
        else
          index_queue.push_back(10'($urandom_range(0, 1023)));
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/sav_pkg.sv
hw/rtl/sav_squeeze.sv
hw/rtl/sav_phase_div.sv
hw/rtl/sav_cordic.sv
hw/rtl/squeezed_arc_vertex_generator.sv
test/squeezed_arc_vertex_generator_tb.sv
